FILE: hdl/i2cseq_pkg.sv
// types and constants shared by the i2c transaction sequencer
package i2cseq_pkg;

    typedef enum logic [1:0] {
        OP_BEGIN  = 2'd0,
        OP_SUPPLY = 2'd1,
        OP_STEP   = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        CMD_NONE    = 3'd0,
        CMD_START   = 3'd1,
        CMD_SEND    = 3'd2,
        CMD_RX_ACK  = 3'd3,
        CMD_RX_NACK = 3'd4,
        CMD_STOP    = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        OC_OK  = 2'd0,
        OC_NAK = 2'd1,
        OC_ERR = 2'd2
    } t_outcome;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_W_START = 4'd1,
        PH_W_ADDR  = 4'd2,
        PH_W_WAIT  = 4'd3,
        PH_W_DATA  = 4'd4,
        PH_R_START = 4'd5,
        PH_R_ADDR  = 4'd6,
        PH_R_ACK   = 4'd7,
        PH_R_NACK  = 4'd8
    } t_phase;

    localparam logic [7:0] ST_MASK       = 8'hf8;
    localparam logic [7:0] ST_START      = 8'h08;
    localparam logic [7:0] ST_RSTART     = 8'h10;
    localparam logic [7:0] ST_AW_ACK     = 8'h18;
    localparam logic [7:0] ST_AW_NAK     = 8'h20;
    localparam logic [7:0] ST_DW_ACK     = 8'h28;
    localparam logic [7:0] ST_DW_NAK     = 8'h30;
    localparam logic [7:0] ST_AR_ACK     = 8'h40;
    localparam logic [7:0] ST_AR_NAK     = 8'h48;
    localparam logic [7:0] ST_DR_ACK     = 8'h50;
    localparam logic [7:0] ST_DR_NAK     = 8'h58;
    localparam logic [7:0] ADDR_WR_MASK  = 8'hfe;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  target_addr;
        logic [15:0] write_count;
        logic [15:0] read_count;
        logic [7:0]  write_byte;
        logic [7:0]  bus_status;
        logic [7:0]  received_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] tx_byte;
        logic       need_write_byte;
        logic       read_valid;
        logic [7:0] read_data;
        logic       done_res;
        logic [1:0] outcome;
        logic [7:0] final_code;
    } t_out_item;

endpackage

FILE: hdl/i2cseq_core.sv
// transaction state machine: phase, byte counters and result decode
module i2cseq_core #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  i2cseq_pkg::t_in_item i_item,
    output i2cseq_pkg::t_out_item o_result
);

    i2cseq_pkg::t_phase     r_phase, n_phase;
    logic [COUNT_WIDTH-1:0] r_btw, n_btw;
    logic [COUNT_WIDTH-1:0] r_btr, n_btr;
    logic                   r_wdf, n_wdf;
    logic [7:0]             r_taddr, n_taddr;

    logic [7:0]             st;
    logic [COUNT_WIDTH-1:0] wc;
    logic [COUNT_WIDTH-1:0] rc;
    logic [7:0]             rstart_code;

    assign st          = i_item.bus_status & i2cseq_pkg::ST_MASK;
    assign wc          = i_item.write_count[COUNT_WIDTH-1:0];
    assign rc          = i_item.read_count[COUNT_WIDTH-1:0];
    assign rstart_code = r_wdf ? i2cseq_pkg::ST_RSTART : i2cseq_pkg::ST_START;

    // next state
    always_comb begin
        n_phase = r_phase;
        n_btw   = r_btw;
        n_btr   = r_btr;
        n_wdf   = r_wdf;
        n_taddr = r_taddr;
        if (i_accept) begin
            unique case (i_item.operation)
                i2cseq_pkg::OP_BEGIN: begin
                    if (r_phase == i2cseq_pkg::PH_IDLE) begin
                        n_taddr = i_item.target_addr;
                        n_btw   = wc;
                        n_btr   = rc;
                        n_wdf   = 1'b0;
                        if (wc != '0) begin
                            n_phase = i2cseq_pkg::PH_W_START;
                        end else if (rc != '0) begin
                            n_phase = i2cseq_pkg::PH_R_START;
                        end
                    end
                end
                i2cseq_pkg::OP_SUPPLY: begin
                    if (r_phase == i2cseq_pkg::PH_W_WAIT) begin
                        n_btw   = r_btw - COUNT_WIDTH'(1);
                        n_phase = i2cseq_pkg::PH_W_DATA;
                    end
                end
                i2cseq_pkg::OP_STEP: begin
                    unique case (r_phase)
                        i2cseq_pkg::PH_W_START: begin
                            n_phase = (st == i2cseq_pkg::ST_START) ?
                                      i2cseq_pkg::PH_W_ADDR : i2cseq_pkg::PH_IDLE;
                        end
                        i2cseq_pkg::PH_W_ADDR, i2cseq_pkg::PH_W_DATA: begin
                            if ((r_phase == i2cseq_pkg::PH_W_ADDR &&
                                 st == i2cseq_pkg::ST_AW_ACK) ||
                                (r_phase == i2cseq_pkg::PH_W_DATA &&
                                 st == i2cseq_pkg::ST_DW_ACK)) begin
                                if (r_btw != '0) begin
                                    n_phase = i2cseq_pkg::PH_W_WAIT;
                                end else if (r_btr != '0) begin
                                    n_wdf   = 1'b1;
                                    n_phase = i2cseq_pkg::PH_R_START;
                                end else begin
                                    n_phase = i2cseq_pkg::PH_IDLE;
                                end
                            end else begin
                                n_phase = i2cseq_pkg::PH_IDLE;
                            end
                        end
                        i2cseq_pkg::PH_R_START: begin
                            n_phase = (st == rstart_code) ?
                                      i2cseq_pkg::PH_R_ADDR : i2cseq_pkg::PH_IDLE;
                        end
                        i2cseq_pkg::PH_R_ADDR, i2cseq_pkg::PH_R_ACK: begin
                            if ((r_phase == i2cseq_pkg::PH_R_ADDR &&
                                 st == i2cseq_pkg::ST_AR_ACK) ||
                                (r_phase == i2cseq_pkg::PH_R_ACK &&
                                 st == i2cseq_pkg::ST_DR_ACK)) begin
                                n_phase = (r_btr > COUNT_WIDTH'(1)) ?
                                          i2cseq_pkg::PH_R_ACK : i2cseq_pkg::PH_R_NACK;
                                n_btr   = r_btr - COUNT_WIDTH'(1);
                            end else begin
                                n_phase = i2cseq_pkg::PH_IDLE;
                            end
                        end
                        i2cseq_pkg::PH_R_NACK: begin
                            n_phase = i2cseq_pkg::PH_IDLE;
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    // result decode
    always_comb begin
        o_result = '0;
        unique case (i_item.operation)
            i2cseq_pkg::OP_BEGIN: begin
                if (r_phase == i2cseq_pkg::PH_IDLE) begin
                    if (wc != '0 || rc != '0) begin
                        o_result.command = i2cseq_pkg::CMD_START;
                    end else begin
                        o_result.done_res = 1'b1;
                    end
                end
            end
            i2cseq_pkg::OP_SUPPLY: begin
                if (r_phase == i2cseq_pkg::PH_W_WAIT) begin
                    o_result.command = i2cseq_pkg::CMD_SEND;
                    o_result.tx_byte = i_item.write_byte;
                end
            end
            i2cseq_pkg::OP_STEP: begin
                unique case (r_phase)
                    i2cseq_pkg::PH_W_START, i2cseq_pkg::PH_R_START: begin
                        if (r_phase == i2cseq_pkg::PH_W_START &&
                            st == i2cseq_pkg::ST_START) begin
                            o_result.command = i2cseq_pkg::CMD_SEND;
                            o_result.tx_byte = r_taddr & i2cseq_pkg::ADDR_WR_MASK;
                        end else if (r_phase == i2cseq_pkg::PH_R_START &&
                                     st == rstart_code) begin
                            o_result.command = i2cseq_pkg::CMD_SEND;
                            o_result.tx_byte = r_taddr | 8'h01;
                        end else begin
                            o_result.done_res   = 1'b1;
                            o_result.outcome    = i2cseq_pkg::OC_ERR;
                            o_result.final_code = st;
                        end
                    end
                    i2cseq_pkg::PH_W_ADDR, i2cseq_pkg::PH_W_DATA: begin
                        if ((r_phase == i2cseq_pkg::PH_W_ADDR &&
                             st == i2cseq_pkg::ST_AW_ACK) ||
                            (r_phase == i2cseq_pkg::PH_W_DATA &&
                             st == i2cseq_pkg::ST_DW_ACK)) begin
                            if (r_btw != '0) begin
                                o_result.need_write_byte = 1'b1;
                            end else if (r_btr != '0) begin
                                o_result.command = i2cseq_pkg::CMD_START;
                            end else begin
                                o_result.command  = i2cseq_pkg::CMD_STOP;
                                o_result.done_res = 1'b1;
                            end
                        end else if ((r_phase == i2cseq_pkg::PH_W_ADDR &&
                                      st == i2cseq_pkg::ST_AW_NAK) ||
                                     (r_phase == i2cseq_pkg::PH_W_DATA &&
                                      st == i2cseq_pkg::ST_DW_NAK)) begin
                            o_result.command    = i2cseq_pkg::CMD_STOP;
                            o_result.done_res   = 1'b1;
                            o_result.outcome    = i2cseq_pkg::OC_NAK;
                            o_result.final_code = st;
                        end else begin
                            o_result.done_res   = 1'b1;
                            o_result.outcome    = i2cseq_pkg::OC_ERR;
                            o_result.final_code = st;
                        end
                    end
                    i2cseq_pkg::PH_R_ADDR, i2cseq_pkg::PH_R_ACK: begin
                        if ((r_phase == i2cseq_pkg::PH_R_ADDR &&
                             st == i2cseq_pkg::ST_AR_ACK) ||
                            (r_phase == i2cseq_pkg::PH_R_ACK &&
                             st == i2cseq_pkg::ST_DR_ACK)) begin
                            o_result.command = (r_btr > COUNT_WIDTH'(1)) ?
                                               i2cseq_pkg::CMD_RX_ACK :
                                               i2cseq_pkg::CMD_RX_NACK;
                            if (r_phase == i2cseq_pkg::PH_R_ACK) begin
                                o_result.read_valid = 1'b1;
                                o_result.read_data  = i_item.received_byte;
                            end
                        end else if (r_phase == i2cseq_pkg::PH_R_ADDR &&
                                     st == i2cseq_pkg::ST_AR_NAK) begin
                            o_result.command    = i2cseq_pkg::CMD_STOP;
                            o_result.done_res   = 1'b1;
                            o_result.outcome    = i2cseq_pkg::OC_NAK;
                            o_result.final_code = st;
                        end else begin
                            o_result.done_res   = 1'b1;
                            o_result.outcome    = i2cseq_pkg::OC_ERR;
                            o_result.final_code = st;
                        end
                    end
                    i2cseq_pkg::PH_R_NACK: begin
                        if (st == i2cseq_pkg::ST_DR_NAK) begin
                            o_result.command    = i2cseq_pkg::CMD_STOP;
                            o_result.done_res   = 1'b1;
                            o_result.read_valid = 1'b1;
                            o_result.read_data  = i_item.received_byte;
                        end else begin
                            o_result.done_res   = 1'b1;
                            o_result.outcome    = i2cseq_pkg::OC_ERR;
                            o_result.final_code = st;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= i2cseq_pkg::PH_IDLE;
            r_btw   <= '0;
            r_btr   <= '0;
            r_wdf   <= 1'b0;
            r_taddr <= '0;
        end else begin
            r_phase <= n_phase;
            r_btw   <= n_btw;
            r_btr   <= n_btr;
            r_wdf   <= n_wdf;
            r_taddr <= n_taddr;
        end
    end

endmodule

FILE: hdl/i2cseq_skid.sv
// two-entry output register with skid stage for result transactions
module i2cseq_skid (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  i2cseq_pkg::t_out_item i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output i2cseq_pkg::t_out_item o_data
);

    logic                  r_main_valid, n_main_valid;
    logic                  r_skid_valid, n_skid_valid;
    i2cseq_pkg::t_out_item r_main, n_main;
    i2cseq_pkg::t_out_item r_skid, n_skid;
    logic                  push;
    logic                  pop;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;
    assign push    = i_valid && !r_skid_valid;
    assign pop     = r_main_valid && i_ready;

    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (pop) begin
            if (r_skid_valid) begin
                n_main       = r_skid;
                n_skid_valid = 1'b0;
            end else if (push) begin
                n_main = i_data;
            end else begin
                n_main_valid = 1'b0;
            end
        end else if (push) begin
            if (!r_main_valid) begin
                n_main       = i_data;
                n_main_valid = 1'b1;
            end else begin
                n_skid       = i_data;
                n_skid_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_main <= n_main;
        r_skid <= n_skid;
    end

endmodule

FILE: hdl/i2c_master_transaction_sequencer.sv
// top level of the i2c master write-then-read transaction sequencer
//
// channel   direction  handshake                 payload
// in        input      i_in_valid / o_in_ready   i_in_data   (t_in_item)
// out       output     o_out_valid / i_out_ready o_out_data  (t_out_item)
//
// one result transaction per input transaction, held in the output register until taken
// an input transaction is taken every cycle while o_in_ready is high; the state machine updates in that cycle
// o_in_ready drops only when both output entries hold results not yet taken
// synchronous active-low reset returns the phase to idle and clears the counters
module i2c_master_transaction_sequencer #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  i2cseq_pkg::t_in_item  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output i2cseq_pkg::t_out_item o_out_data
);

    logic                  in_accept;
    i2cseq_pkg::t_out_item result;

    assign in_accept = i_in_valid && o_in_ready;

    i2cseq_core #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_item   (i_in_data),
        .o_result (result)
    );

    i2cseq_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_accept),
        .o_ready (o_in_ready),
        .i_data  (result),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_out_valid)
        else $error("accepted transaction produced no result");

    a_full_means_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no result pending");

    a_not_done_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.done_res) |->
            (o_out_data.outcome == i2cseq_pkg::OC_OK && o_out_data.final_code == 8'd0))
        else $error("outcome or final code set on a non-final result");

    a_read_data_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.read_valid) |-> (o_out_data.read_data == 8'd0))
        else $error("read data present without read valid");

endmodule

FILE: verif/i2cseq_checker.sv
`timescale 1ns / 1ps
// checker for the i2c transaction sequencer: predicts every bus action and compares results
module i2cseq_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  i2cseq_pkg::t_in_item  i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  i2cseq_pkg::t_out_item i_out_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam logic [7:0] DIR_READ = 8'h01;

    i2cseq_pkg::t_phase    ph = i2cseq_pkg::PH_IDLE;
    logic [15:0]           wr_left = '0;
    logic [15:0]           rd_left = '0;
    logic                  wr_done = 1'b0;
    logic [7:0]            dev_addr = '0;
    i2cseq_pkg::t_out_item act;
    i2cseq_pkg::t_out_item want;
    i2cseq_pkg::t_out_item bus_actions_due[$];
    int                    fails = 0;
    int                    due_n = 0;

    assign o_fail_count = fails;
    assign o_pending    = due_n;

    function automatic void end_txn(input i2cseq_pkg::t_cmd cmd,
                                    input i2cseq_pkg::t_outcome oc,
                                    input logic [7:0] code);
        act.command    = cmd;
        act.done_res   = 1'b1;
        act.outcome    = oc;
        act.final_code = code;
        ph = i2cseq_pkg::PH_IDLE;
    endfunction

    function automatic void next_receive();
        if (rd_left > 16'd1) begin
            act.command = i2cseq_pkg::CMD_RX_ACK;
            ph = i2cseq_pkg::PH_R_ACK;
        end else begin
            act.command = i2cseq_pkg::CMD_RX_NACK;
            ph = i2cseq_pkg::PH_R_NACK;
        end
        rd_left = rd_left - 16'd1;
    endfunction

    function automatic void read_or_stop();
        if (rd_left != 16'd0) begin
            act.command = i2cseq_pkg::CMD_START;
            wr_done = 1'b1;
            ph = i2cseq_pkg::PH_R_START;
        end else begin
            end_txn(i2cseq_pkg::CMD_STOP, i2cseq_pkg::OC_OK, 8'h00);
        end
    endfunction

    function automatic void sequence_step(input i2cseq_pkg::t_in_item it);
        logic [7:0] st;
        st = it.bus_status & i2cseq_pkg::ST_MASK;
        act = '0;
        case (it.operation)
            i2cseq_pkg::OP_BEGIN: begin
                if (ph == i2cseq_pkg::PH_IDLE) begin
                    dev_addr = it.target_addr;
                    wr_left  = it.write_count;
                    rd_left  = it.read_count;
                    wr_done  = 1'b0;
                    if (wr_left != 16'd0) begin
                        act.command = i2cseq_pkg::CMD_START;
                        ph = i2cseq_pkg::PH_W_START;
                    end else if (rd_left != 16'd0) begin
                        act.command = i2cseq_pkg::CMD_START;
                        ph = i2cseq_pkg::PH_R_START;
                    end else begin
                        end_txn(i2cseq_pkg::CMD_NONE, i2cseq_pkg::OC_OK, 8'h00);
                    end
                end
            end
            i2cseq_pkg::OP_SUPPLY: begin
                if (ph == i2cseq_pkg::PH_W_WAIT) begin
                    act.command = i2cseq_pkg::CMD_SEND;
                    act.tx_byte = it.write_byte;
                    wr_left = wr_left - 16'd1;
                    ph = i2cseq_pkg::PH_W_DATA;
                end
            end
            i2cseq_pkg::OP_STEP: begin
                case (ph)
                    i2cseq_pkg::PH_W_START: begin
                        if (st != i2cseq_pkg::ST_START) begin
                            end_txn(i2cseq_pkg::CMD_NONE, i2cseq_pkg::OC_ERR, st);
                        end else begin
                            act.command = i2cseq_pkg::CMD_SEND;
                            act.tx_byte = dev_addr & i2cseq_pkg::ADDR_WR_MASK;
                            ph = i2cseq_pkg::PH_W_ADDR;
                        end
                    end
                    i2cseq_pkg::PH_W_ADDR, i2cseq_pkg::PH_W_DATA: begin
                        if (st == ((ph == i2cseq_pkg::PH_W_ADDR) ? i2cseq_pkg::ST_AW_ACK
                                                                 : i2cseq_pkg::ST_DW_ACK)) begin
                            if (wr_left != 16'd0) begin
                                act.need_write_byte = 1'b1;
                                ph = i2cseq_pkg::PH_W_WAIT;
                            end else begin
                                read_or_stop();
                            end
                        end else if (st == ((ph == i2cseq_pkg::PH_W_ADDR) ?
                                            i2cseq_pkg::ST_AW_NAK :
                                            i2cseq_pkg::ST_DW_NAK)) begin
                            end_txn(i2cseq_pkg::CMD_STOP, i2cseq_pkg::OC_NAK, st);
                        end else begin
                            end_txn(i2cseq_pkg::CMD_NONE, i2cseq_pkg::OC_ERR, st);
                        end
                    end
                    i2cseq_pkg::PH_R_START: begin
                        if (st != (wr_done ? i2cseq_pkg::ST_RSTART : i2cseq_pkg::ST_START)) begin
                            end_txn(i2cseq_pkg::CMD_NONE, i2cseq_pkg::OC_ERR, st);
                        end else begin
                            act.command = i2cseq_pkg::CMD_SEND;
                            act.tx_byte = dev_addr | DIR_READ;
                            ph = i2cseq_pkg::PH_R_ADDR;
                        end
                    end
                    i2cseq_pkg::PH_R_ADDR: begin
                        if (st == i2cseq_pkg::ST_AR_ACK) begin
                            next_receive();
                        end else if (st == i2cseq_pkg::ST_AR_NAK) begin
                            end_txn(i2cseq_pkg::CMD_STOP, i2cseq_pkg::OC_NAK, st);
                        end else begin
                            end_txn(i2cseq_pkg::CMD_NONE, i2cseq_pkg::OC_ERR, st);
                        end
                    end
                    i2cseq_pkg::PH_R_ACK: begin
                        if (st == i2cseq_pkg::ST_DR_ACK) begin
                            act.read_valid = 1'b1;
                            act.read_data  = it.received_byte;
                            next_receive();
                        end else begin
                            end_txn(i2cseq_pkg::CMD_NONE, i2cseq_pkg::OC_ERR, st);
                        end
                    end
                    i2cseq_pkg::PH_R_NACK: begin
                        if (st == i2cseq_pkg::ST_DR_NAK) begin
                            act.read_valid = 1'b1;
                            act.read_data  = it.received_byte;
                            end_txn(i2cseq_pkg::CMD_STOP, i2cseq_pkg::OC_OK, 8'h00);
                        end else begin
                            end_txn(i2cseq_pkg::CMD_NONE, i2cseq_pkg::OC_ERR, st);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void match_field(input string name, input logic [7:0] exp_v,
                                        input logic [7:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s: expected %0d, actual %0d", name, exp_v, got_v);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ph       = i2cseq_pkg::PH_IDLE;
            wr_left  = '0;
            rd_left  = '0;
            wr_done  = 1'b0;
            dev_addr = '0;
            bus_actions_due.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                sequence_step(i_in_data);
                bus_actions_due.push_back(act);
            end
            if (i_out_valid && i_out_ready) begin
                if (bus_actions_due.size() == 0) begin
                    $error("result with no transaction pending: %h", i_out_data);
                    fails++;
                end else begin
                    want = bus_actions_due.pop_front();
                    match_field("command", 8'(want.command), 8'(i_out_data.command));
                    match_field("tx_byte", want.tx_byte, i_out_data.tx_byte);
                    match_field("need_write_byte", 8'(want.need_write_byte),
                                8'(i_out_data.need_write_byte));
                    match_field("read_valid", 8'(want.read_valid), 8'(i_out_data.read_valid));
                    match_field("read_data", want.read_data, i_out_data.read_data);
                    match_field("done_res", 8'(want.done_res), 8'(i_out_data.done_res));
                    match_field("outcome", 8'(want.outcome), 8'(i_out_data.outcome));
                    match_field("final_code", want.final_code, i_out_data.final_code);
                end
            end
        end
        due_n = bus_actions_due.size();
    end

endmodule

FILE: verif/i2c_master_transaction_sequencer_tb.sv
`timescale 1ns / 1ps
// testbench top for the i2c transaction sequencer: drives bus transactions and reports the verdict
module i2c_master_transaction_sequencer_tb;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [7:0] NO_NAK    = 8'h00;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    i2cseq_pkg::t_in_item  in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    i2cseq_pkg::t_out_item out_data;
    int                    fail_count;
    int                    pending;
    bit                    steady = 1'b0;
    bit                    noisy = 1'b0;
    int                    real_items = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    i2c_master_transaction_sequencer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    i2cseq_checker chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // stretches with no idling on either side
    always @(negedge clk) begin
        if ($urandom_range(0, 399) == 0) steady <= ~steady;
    end

    function automatic int pause_len();
        if (steady) return 0;
        return $urandom_range(0, 13);
    endfunction

    function automatic i2cseq_pkg::t_in_item rand_item(input logic [1:0] op);
        i2cseq_pkg::t_in_item it;
        it.operation     = op;
        it.target_addr   = 8'($urandom);
        it.write_count   = 16'($urandom);
        it.read_count    = 16'($urandom);
        it.write_byte    = 8'($urandom);
        it.bus_status    = 8'($urandom);
        it.received_byte = 8'($urandom);
        return it;
    endfunction

    task automatic send_item(input i2cseq_pkg::t_in_item it, input bit counts);
        int gap;
        gap = pause_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data  <= it;
        in_valid <= 1'b1;
        do @(posedge clk); while (!(in_valid && in_ready));
        @(negedge clk);
        if (counts) real_items++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
    endtask

    // ignored transaction; alt is the third kind that is out of phase here
    task automatic stray_item(input logic [1:0] alt);
        case ($urandom_range(0, 2))
            0: send_item(rand_item(OP_UNUSED), 1'b0);
            1: send_item(rand_item(i2cseq_pkg::OP_SUPPLY), 1'b0);
            default: send_item(rand_item(alt), 1'b0);
        endcase
    endtask

    task automatic bus_reply(input logic [7:0] ack, input logic [7:0] nak, input int fail_at,
                             inout int k, output bit ended);
        i2cseq_pkg::t_in_item it;
        logic [7:0]           st;
        if (noisy && $urandom_range(0, 11) == 0) stray_item(i2cseq_pkg::OP_BEGIN);
        k++;
        ended = (k == fail_at);
        st = ack;
        if (ended) begin
            if (nak != NO_NAK && $urandom_range(0, 1) == 1) begin
                st = nak;
            end else begin
                do st = 8'($urandom); while ((st & i2cseq_pkg::ST_MASK) == ack);
            end
        end
        it = rand_item(i2cseq_pkg::OP_STEP);
        it.bus_status = st | (8'($urandom) & ~i2cseq_pkg::ST_MASK);
        send_item(it, 1'b1);
    endtask

    task automatic run_txn(input logic [7:0] addr, input logic [15:0] wc, input logic [15:0] rc,
                           input int fail_at);
        i2cseq_pkg::t_in_item it;
        int                   k;
        bit                   ended;
        k = 0;
        it = rand_item(i2cseq_pkg::OP_BEGIN);
        it.target_addr = addr;
        it.write_count = wc;
        it.read_count  = rc;
        send_item(it, 1'b1);
        if (wc != 16'd0) begin
            bus_reply(i2cseq_pkg::ST_START, NO_NAK, fail_at, k, ended);
            if (ended) return;
            bus_reply(i2cseq_pkg::ST_AW_ACK, i2cseq_pkg::ST_AW_NAK, fail_at, k, ended);
            if (ended) return;
            for (int i = 0; i < int'(wc); i++) begin
                if (noisy && $urandom_range(0, 11) == 0) begin
                    send_item(rand_item(i2cseq_pkg::OP_STEP), 1'b0);
                end
                send_item(rand_item(i2cseq_pkg::OP_SUPPLY), 1'b1);
                bus_reply(i2cseq_pkg::ST_DW_ACK, i2cseq_pkg::ST_DW_NAK, fail_at, k, ended);
                if (ended) return;
            end
        end
        if (rc != 16'd0) begin
            bus_reply((wc != 16'd0) ? i2cseq_pkg::ST_RSTART : i2cseq_pkg::ST_START, NO_NAK,
                      fail_at, k, ended);
            if (ended) return;
            bus_reply(i2cseq_pkg::ST_AR_ACK, i2cseq_pkg::ST_AR_NAK, fail_at, k, ended);
            if (ended) return;
            for (int i = 1; i < int'(rc); i++) begin
                bus_reply(i2cseq_pkg::ST_DR_ACK, NO_NAK, fail_at, k, ended);
                if (ended) return;
            end
            bus_reply(i2cseq_pkg::ST_DR_NAK, NO_NAK, fail_at, k, ended);
        end
    endtask

    initial begin
        int gap;
        @(posedge rst_n);
        forever begin
            gap = pause_len();
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
            @(negedge clk);
        end
    end

    initial begin
        logic [15:0] wc;
        logic [15:0] rc;
        int          steps;
        int          fail_at;
        int          n_txn;
        n_txn = 0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // nothing to do, full write-then-read, wide counts cut short, read only, address nak or bus error
        run_txn(8'hff, 16'd0, 16'd0, 0);
        run_txn(8'h00, 16'd0, 16'd0, 0);
        run_txn(8'ha5, 16'd1, 16'd1, 0);
        run_txn(8'h00, 16'hffff, 16'hffff, 1);
        run_txn(8'h5a, 16'd0, 16'd2, 0);
        run_txn(8'h3c, 16'd1, 16'd0, 2);
        send_item(rand_item(OP_UNUSED), 1'b0);
        send_item(rand_item(i2cseq_pkg::OP_SUPPLY), 1'b0);
        send_item(rand_item(i2cseq_pkg::OP_STEP), 1'b0);
        drain();

        noisy = 1'b1;
        while (real_items < 1950) begin
            if ($urandom_range(0, 9) == 0) stray_item(i2cseq_pkg::OP_STEP);
            if ($urandom_range(0, 15) == 0) begin
                wc = 16'($urandom);
                rc = 16'($urandom);
                fail_at = $urandom_range(1, 3);
            end else begin
                wc = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(5, 16))
                                                 : 16'($urandom_range(0, 4));
                rc = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(5, 16))
                                                 : 16'($urandom_range(0, 4));
                steps = ((wc != 16'd0) ? int'(wc) + 2 : 0) + ((rc != 16'd0) ? int'(rc) + 2 : 0);
                fail_at = (steps > 0 && $urandom_range(0, 3) == 0) ? $urandom_range(1, steps) : 0;
            end
            run_txn(8'($urandom), wc, rc, fail_at);
            n_txn++;
            if (n_txn % 64 == 0) drain();
        end

        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (8) @(posedge clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
